// ===== rtl/bto_pkg.sv =====
// Shared types and constants of the binomial tree option pricer.
// Used by bto_cell, bto_unit and binomial_tree_option_pricer; depends on nothing.
package bto_pkg;

  // Largest expiry layer and the derived widths.
  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES + 1);
  localparam int LAT       = 5;
  localparam int CYC_W     = $clog2(MAX_NODES + LAT);
  localparam int STEPS_W   = 11;
  localparam int CMP_W     = (NODE_W > STEPS_W) ? NODE_W : STEPS_W;

  // Configuration register indexes.
  localparam logic [2:0] REG_UP    = 3'd0;
  localparam logic [2:0] REG_DOWN  = 3'd1;
  localparam logic [2:0] REG_INVUP = 3'd2;
  localparam logic [2:0] REG_PROB  = 3'd3;
  localparam logic [2:0] REG_DISC  = 3'd4;
  localparam logic [2:0] REG_STEPS = 3'd5;
  localparam logic [2:0] REG_KIND  = 3'd6;

  // Operation codes of the node update unit.
  localparam logic [1:0] OP_PASS = 2'd0;
  localparam logic [1:0] OP_SPOT = 2'd1;
  localparam logic [1:0] OP_PAY  = 2'd2;
  localparam logic [1:0] OP_NODE = 2'd3;

  typedef struct packed {
    logic [31:0] spot_price;
    logic [31:0] strike_price;
  } in_req_t;

  typedef struct packed {
    logic [31:0] option_value;
    logic        saturated;
  } out_rsp_t;

  // One tree node as held in a cell.
  typedef struct packed {
    logic [31:0] value;
    logic [31:0] spot;
  } node_t;

  // Work issued to the update unit for one node.
  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [31:0] a;
    logic [31:0] f;
    logic [31:0] vlo;
    logic [31:0] vhi;
    logic [31:0] pspot;
    logic [31:0] pval;
  } op_t;

  // Finished node coming back from the unit.
  typedef struct packed {
    logic  valid;
    logic  sat;
    node_t node;
  } res_t;

endpackage

// ===== rtl/bto_cell.sv =====
// One cell of the rotating node ring: holds one node and shifts toward the head.
// Depends on bto_pkg.
module bto_cell (
  input  logic           clk_i,
  input  logic           load_i,
  input  logic           shift_i,
  input  logic           tail_i,
  input  logic [31:0]    spot_i,
  input  bto_pkg::node_t nbr_i,
  input  bto_pkg::node_t tail_feed_i,
  output bto_pkg::node_t node_o
);

  bto_pkg::node_t node_q;
  bto_pkg::node_t node_d;

  // A new option seeds every cell with the spot; a shift takes the neighbor
  // or, at the ring's tail, the returning node.
  always_comb begin
    node_d = node_q;
    if (load_i) begin
      node_d.spot  = spot_i;
      node_d.value = '0;
    end else if (shift_i) begin
      node_d = tail_i ? tail_feed_i : nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q <= node_d;
  end

  assign node_o = node_q;

endmodule

// ===== rtl/bto_unit.sv =====
// Five-stage node update unit: spot products, weighted average, discount, payoff.
// Depends on bto_pkg.
module bto_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  bto_pkg::op_t op_i,
  input  logic [31:0]  prob_i,
  input  logic [31:0]  disc_i,
  input  logic [31:0]  strike_i,
  input  logic [1:0]   kind_i,
  output bto_pkg::res_t res_o
);

  function automatic logic [31:0] payoff(input logic [31:0] s, input logic [31:0] x,
                                         input logic put);
    logic [31:0] r;
    begin
      r = '0;
      if (put) begin
        if (x > s) r = x - s;
      end else begin
        if (s > x) r = s - x;
      end
      return r;
    end
  endfunction

  // Stage A: captured request.
  logic         va_q;
  bto_pkg::op_t op_q;

  // Stage B: products.
  logic         vb_q;
  logic [1:0]   mode_b_q;
  logic [63:0]  sprod_b_q;
  logic [64:0]  plo_b_q;
  logic [63:0]  phi_b_q;
  logic [31:0]  pspot_b_q, pval_b_q;

  // Stage C: rounded spot and average.
  logic         vc_q, sat_c_q;
  logic [1:0]   mode_c_q;
  logic [31:0]  spot_c_q, avg_c_q, pspot_c_q, pval_c_q;

  // Stage D: discounted product.
  logic         vd_q, sat_d_q;
  logic [1:0]   mode_d_q;
  logic [63:0]  dprod_d_q;
  logic [31:0]  spot_d_q, pspot_d_q, pval_d_q;

  // Stage E: finished node.
  logic          ve_q, sat_e_q;
  bto_pkg::node_t node_e_q;

  logic [32:0] pdn;
  logic [34:0] spr;
  logic [65:0] asum;
  logic [64:0] dsum;
  logic [31:0] vdisc, ex, vmax;
  logic        spr_sat;
  bto_pkg::node_t node_d;
  logic        sat_e_d;

  assign pdn     = 33'h1_0000_0000 - {1'b0, prob_i};
  assign spr     = 35'((65'(sprod_b_q) + 65'h2000_0000) >> 30);
  assign spr_sat = |spr[34:32];
  assign asum    = 66'(plo_b_q) + 66'(phi_b_q) + 66'h8000_0000;
  assign dsum    = 65'(dprod_d_q) + 65'h8000_0000;
  assign vdisc   = dsum[63:32];
  assign ex      = payoff(spot_d_q, strike_i, kind_i[0]);
  assign vmax    = (kind_i[1] && (ex > vdisc)) ? ex : vdisc;

  // Output selection by operation.
  always_comb begin
    node_d.spot  = pspot_d_q;
    node_d.value = pval_d_q;
    sat_e_d      = 1'b0;
    case (mode_d_q)
      bto_pkg::OP_SPOT: begin
        node_d.spot = spot_d_q;
        sat_e_d     = sat_d_q;
      end
      bto_pkg::OP_PAY: begin
        node_d.value = payoff(pspot_d_q, strike_i, kind_i[0]);
      end
      bto_pkg::OP_NODE: begin
        node_d.spot  = spot_d_q;
        node_d.value = vmax;
        sat_e_d      = sat_d_q;
      end
      default: begin
        node_d.spot = pspot_d_q;
      end
    endcase
  end

  // Valid bits of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      va_q <= op_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk_i) begin
    op_q      <= op_i;
    mode_b_q  <= op_q.mode;
    sprod_b_q <= 64'(op_q.a) * 64'(op_q.f);
    plo_b_q   <= 65'(op_q.vlo) * 65'(pdn);
    phi_b_q   <= 64'(op_q.vhi) * 64'(prob_i);
    pspot_b_q <= op_q.pspot;
    pval_b_q  <= op_q.pval;
    mode_c_q  <= mode_b_q;
    sat_c_q   <= spr_sat;
    spot_c_q  <= spr_sat ? 32'hFFFF_FFFF : spr[31:0];
    avg_c_q   <= asum[63:32];
    pspot_c_q <= pspot_b_q;
    pval_c_q  <= pval_b_q;
    mode_d_q  <= mode_c_q;
    sat_d_q   <= sat_c_q;
    dprod_d_q <= 64'(avg_c_q) * 64'(disc_i);
    spot_d_q  <= spot_c_q;
    pspot_d_q <= pspot_c_q;
    pval_d_q  <= pval_c_q;
    node_e_q  <= node_d;
    sat_e_q   <= sat_e_d;
  end

  assign res_o.valid = ve_q;
  assign res_o.sat   = sat_e_q;
  assign res_o.node  = node_e_q;

endmodule

// ===== rtl/binomial_tree_option_pricer.sv =====
// Binomial tree option pricer: one option per request, root value in Q16.16.
// For n expiry nodes, n-1 passes build the expiry spots, one pass sets the
// payoffs and n-1 passes walk the tree back. Each pass rotates the ring of n node
// cells once through the five-stage update unit, one node per cycle. After the
// last pass the result state loads the output register and the pricer goes back
// to idle, where it takes the next request; a result still waiting in the output
// register holds the pricer in the result state. Depends on bto_pkg, bto_cell
// and bto_unit.
module binomial_tree_option_pricer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bto_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bto_pkg::out_rsp_t out_rsp_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SPOT = 3'd1;
  localparam logic [2:0] ST_PAY  = 3'd2;
  localparam logic [2:0] ST_NODE = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [31:0] up_q, dn_q, iu_q, prob_q, disc_q;
  logic [bto_pkg::STEPS_W-1:0] steps_q;
  logic [1:0]  kind_q;

  logic [2:0]                 state_q, state_d;
  logic [bto_pkg::CYC_W-1:0]  cyc_q, cyc_d;
  logic [bto_pkg::NODE_W-1:0] pass_q, pass_d;
  logic [bto_pkg::NODE_W-1:0] n_q, n_eff;
  logic [31:0]                strike_q, prev_spot_q;
  logic                       sat_q, sat_d;
  logic                       out_valid_q, out_valid_d;
  bto_pkg::out_rsp_t          out_rsp_q, out_rsp_d;

  logic [bto_pkg::CMP_W-1:0]  nreq;
  logic                       accept, busy, issue, pass_end;
  bto_pkg::op_t               op;
  bto_pkg::res_t              res;
  bto_pkg::node_t             tail_feed;
  bto_pkg::node_t             cell_w [bto_pkg::MAX_NODES];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= 32'h4000_0000;
      dn_q    <= 32'h4000_0000;
      iu_q    <= 32'h4000_0000;
      prob_q  <= 32'h8000_0000;
      disc_q  <= 32'hFFFF_FFFF;
      steps_q <= bto_pkg::STEPS_W'(2);
      kind_q  <= 2'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bto_pkg::REG_UP:    up_q    <= cfg_data_i;
        bto_pkg::REG_DOWN:  dn_q    <= cfg_data_i;
        bto_pkg::REG_INVUP: iu_q    <= cfg_data_i;
        bto_pkg::REG_PROB:  prob_q  <= cfg_data_i;
        bto_pkg::REG_DISC:  disc_q  <= cfg_data_i;
        bto_pkg::REG_STEPS: steps_q <= cfg_data_i[bto_pkg::STEPS_W-1:0];
        bto_pkg::REG_KIND:  kind_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Step count clamped to the ring size.
  assign nreq = bto_pkg::CMP_W'(steps_q);
  always_comb begin
    if (nreq < bto_pkg::CMP_W'(2)) begin
      n_eff = bto_pkg::NODE_W'(2);
    end else if (nreq > bto_pkg::CMP_W'(bto_pkg::MAX_NODES)) begin
      n_eff = bto_pkg::NODE_W'(bto_pkg::MAX_NODES);
    end else begin
      n_eff = nreq[bto_pkg::NODE_W-1:0];
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign busy       = (state_q == ST_SPOT) || (state_q == ST_PAY) || (state_q == ST_NODE);
  assign issue      = busy && (cyc_q < bto_pkg::CYC_W'(n_q));
  assign pass_end   = (cyc_q == bto_pkg::CYC_W'(n_q) + bto_pkg::CYC_W'(bto_pkg::LAT - 1));

  // Work for the node now at the head of the ring.
  always_comb begin
    op.valid = issue;
    op.mode  = bto_pkg::OP_PASS;
    op.a     = cell_w[0].spot;
    op.f     = up_q;
    op.vlo   = cell_w[0].value;
    op.vhi   = cell_w[1].value;
    op.pspot = cell_w[0].spot;
    op.pval  = cell_w[0].value;
    case (state_q)
      ST_SPOT: begin
        if (cyc_q < bto_pkg::CYC_W'(pass_q)) begin
          op.mode = bto_pkg::OP_SPOT;
          op.f    = dn_q;
        end else if (cyc_q == bto_pkg::CYC_W'(pass_q)) begin
          op.mode = bto_pkg::OP_SPOT;
          op.a    = prev_spot_q;
        end
      end
      ST_PAY: begin
        op.mode = bto_pkg::OP_PAY;
      end
      ST_NODE: begin
        if (cyc_q <= bto_pkg::CYC_W'(pass_q)) begin
          op.mode = bto_pkg::OP_NODE;
          op.a    = cell_w[1].spot;
          op.f    = iu_q;
        end
      end
      default: ;
    endcase
  end

  bto_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (op),
    .prob_i   (prob_q),
    .disc_i   (disc_q),
    .strike_i (strike_q),
    .kind_i   (kind_q),
    .res_o    (res)
  );

  assign tail_feed = res.valid ? res.node : cell_w[0];

  // Ring of node cells; the tail sits at cell n-1.
  for (genvar j = 0; j < bto_pkg::MAX_NODES; j++) begin : g_cell
    bto_pkg::node_t nbr;
    if (j == bto_pkg::MAX_NODES - 1) begin : g_last
      assign nbr = cell_w[0];
    end else begin : g_mid
      assign nbr = cell_w[j + 1];
    end
    bto_cell u_cell (
      .clk_i       (clk_i),
      .load_i      (accept),
      .shift_i     (busy),
      .tail_i      (n_q == bto_pkg::NODE_W'(j + 1)),
      .spot_i      (in_req_i.spot_price),
      .nbr_i       (nbr),
      .tail_feed_i (tail_feed),
      .node_o      (cell_w[j])
    );
  end

  // Pass sequencer.
  always_comb begin
    state_d     = state_q;
    cyc_d       = cyc_q;
    pass_d      = pass_q;
    sat_d       = sat_q | (res.valid & res.sat);
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SPOT;
          cyc_d   = '0;
          pass_d  = bto_pkg::NODE_W'(1);
          sat_d   = 1'b0;
        end
      end
      ST_SPOT, ST_PAY, ST_NODE: begin
        cyc_d = cyc_q + bto_pkg::CYC_W'(1);
        if (pass_end) begin
          cyc_d = '0;
          if (state_q == ST_SPOT) begin
            if (pass_q == n_q - bto_pkg::NODE_W'(1)) begin
              state_d = ST_PAY;
            end else begin
              pass_d = pass_q + bto_pkg::NODE_W'(1);
            end
          end else if (state_q == ST_PAY) begin
            state_d = ST_NODE;
            pass_d  = n_q - bto_pkg::NODE_W'(2);
          end else begin
            if (pass_q == '0) begin
              state_d = ST_DONE;
            end else begin
              pass_d = pass_q - bto_pkg::NODE_W'(1);
            end
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d                = ST_IDLE;
          out_valid_d            = 1'b1;
          out_rsp_d.option_value = cell_w[0].value;
          out_rsp_d.saturated    = sat_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cyc_q       <= '0;
      pass_q      <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cyc_q       <= cyc_d;
      pass_q      <= pass_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload and head history.
  always_ff @(posedge clk_i) begin
    out_rsp_q   <= out_rsp_d;
    prev_spot_q <= cell_w[0].spot;
    if (accept) begin
      strike_q <= in_req_i.strike_price;
      n_q      <= n_eff;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A finished node returns only while a pass is running.
  a_res_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> busy)
    else $error("update unit returned a node outside a pass");

  // A node returns no earlier than the unit latency into its pass.
  a_res_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (cyc_q >= bto_pkg::CYC_W'(bto_pkg::LAT)))
    else $error("node returned before the pipeline latency");

  // The result stage is entered only from the last induction pass.
  a_done_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DONE) ##1 (state_q == ST_DONE) |-> $past(state_q) == ST_NODE)
    else $error("result state entered from the wrong phase");

  // A new request never starts while a finished node is still returning from the unit.
  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !res.valid)
    else $error("request taken with nodes in flight");

endmodule
